// File: src/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// shared types and codes of the i2c register master: request and result
// layouts, request kinds, operations, bus phases and transfer stages
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 16;

  // request kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_NOOP  = 2'd3;

  // operations
  localparam logic [1:0] OP_PROBE   = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  // bus phases
  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_ST1    = 5'd1;
  localparam logic [4:0] PH_ST2    = 5'd2;
  localparam logic [4:0] PH_ST3    = 5'd3;
  localparam logic [4:0] PH_TXLO   = 5'd4;
  localparam logic [4:0] PH_TXHI   = 5'd5;
  localparam logic [4:0] PH_ACKLO  = 5'd6;
  localparam logic [4:0] PH_ACKHI  = 5'd7;
  localparam logic [4:0] PH_ACKSMP = 5'd8;
  localparam logic [4:0] PH_WAIT   = 5'd9;
  localparam logic [4:0] PH_RXREL  = 5'd10;
  localparam logic [4:0] PH_RXLO   = 5'd11;
  localparam logic [4:0] PH_RXHI   = 5'd12;
  localparam logic [4:0] PH_MALO   = 5'd13;
  localparam logic [4:0] PH_MAHI   = 5'd14;
  localparam logic [4:0] PH_MAREL  = 5'd15;
  localparam logic [4:0] PH_SP1    = 5'd16;
  localparam logic [4:0] PH_SP2    = 5'd17;
  localparam logic [4:0] PH_SP3    = 5'd18;

  // transfer stages
  localparam logic [2:0] SG_DEVW   = 3'd0;
  localparam logic [2:0] SG_ADDRHI = 3'd1;
  localparam logic [2:0] SG_ADDRLO = 3'd2;
  localparam logic [2:0] SG_DATA   = 3'd3;
  localparam logic [2:0] SG_DEVR   = 3'd4;

  localparam logic [7:0] MSB_MASK  = 8'h80;
  localparam logic [7:0] READ_FLAG = 8'h01;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  operation;
    logic [7:0]  device_byte;
    logic [15:0] register_address;
    logic        short_address;
    logic [15:0] transfer_length;
    logic [7:0]  write_byte;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        read_last;
    logic        data_request;
  } result_t;

endpackage

// File: src/i2crm_in_stage.sv
// ----------------------------------------------------------------------------
// i2crm_in_stage
// input register: unpacks and holds one request until the core takes it
// ----------------------------------------------------------------------------
module i2crm_in_stage
  import i2crm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,
  input  logic [InUserW-1:0] s_tuser,
  input  logic               take,
  output logic               held_valid,
  output item_t              held
);

  assign s_tready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held.kind             <= s_tuser;
      held.operation        <= s_tdata[1:0];
      held.device_byte      <= s_tdata[9:2];
      held.register_address <= s_tdata[25:10];
      held.short_address    <= s_tdata[26];
      held.transfer_length  <= s_tdata[42:27];
      held.write_byte       <= s_tdata[50:43];
      held.sda_in           <= s_tdata[51];
    end
  end

endmodule

// File: src/i2crm_core.sv
// ----------------------------------------------------------------------------
// i2crm_core
// bus sequencer: one pin step per tick request, result register toward the
// master-side stream
// ----------------------------------------------------------------------------
module i2crm_core
  import i2crm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                held_valid,
  input  item_t               held,
  output logic                take,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tlast
);

  logic [4:0]  phase, phase_next;
  logic [2:0]  stage, stage_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shifter, shifter_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] reg_addr_hold, reg_addr_hold_next;
  logic [7:0]  dev_hold, dev_hold_next;
  logic [1:0]  op_hold, op_hold_next;
  logic        short_hold, short_hold_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic        pending_valid, pending_valid_next;
  logic        nack_flag, nack_flag_next;
  logic [3:0]  bit_inc;
  logic [15:0] bytes_dec;
  logic [7:0]  shift_in;
  result_t     res, res_next;

  assign take      = held_valid && (!m_tvalid || m_tready);
  assign bit_inc   = bit_count + 4'd1;
  assign bytes_dec = bytes_left - 16'd1;
  assign shift_in  = {shifter[6:0], held.sda_in};

  always_comb begin
    phase_next         = phase;
    stage_next         = stage;
    bit_count_next     = bit_count;
    shifter_next       = shifter;
    bytes_left_next    = bytes_left;
    reg_addr_hold_next = reg_addr_hold;
    dev_hold_next      = dev_hold;
    op_hold_next       = op_hold;
    short_hold_next    = short_hold;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    nack_flag_next     = nack_flag;
    res_next           = '0;

    case (held.kind)
      KIND_START: begin
        if (phase == PH_IDLE && held.operation != OP_INVALID) begin
          op_hold_next       = held.operation;
          dev_hold_next      = held.device_byte;
          reg_addr_hold_next = held.register_address;
          short_hold_next    = held.short_address;
          bytes_left_next    = held.transfer_length;
          // a zero-length read still fetches one byte
          if (held.operation == OP_READ && held.transfer_length == 16'd0) begin
            bytes_left_next = 16'd1;
          end
          shifter_next       = held.device_byte;
          stage_next         = SG_DEVW;
          bit_count_next     = 4'd0;
          nack_flag_next     = 1'b0;
          pending_valid_next = 1'b0;
          phase_next         = PH_ST1;
        end
      end
      KIND_BYTE: begin
        pending_byte_next  = held.write_byte;
        pending_valid_next = 1'b1;
      end
      KIND_TICK: begin
        case (phase)
          PH_IDLE: ;
          PH_ST1: begin
            sda_reg_next = 1'b1;
            phase_next   = PH_ST2;
          end
          PH_ST2: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_ST3;
          end
          PH_ST3: begin
            sda_reg_next   = 1'b0;
            bit_count_next = 4'd0;
            phase_next     = PH_TXLO;
          end
          PH_WAIT: begin
            if (pending_valid) begin
              shifter_next       = pending_byte;
              pending_valid_next = 1'b0;
              bit_count_next     = 4'd0;
              scl_reg_next       = 1'b0;
              sda_reg_next       = |(pending_byte & MSB_MASK);
              phase_next         = PH_TXHI;
            end
          end
          PH_TXLO: begin
            scl_reg_next = 1'b0;
            sda_reg_next = |(shifter & MSB_MASK);
            phase_next   = PH_TXHI;
          end
          PH_TXHI: begin
            scl_reg_next = 1'b1;
            shifter_next = {shifter[6:0], 1'b0};
            if (bit_inc >= 4'd8) begin
              bit_count_next = 4'd0;
              phase_next     = PH_ACKLO;
            end else begin
              bit_count_next = bit_inc;
              phase_next     = PH_TXLO;
            end
          end
          PH_ACKLO: begin
            scl_reg_next = 1'b0;
            sda_reg_next = 1'b1;
            phase_next   = PH_ACKHI;
          end
          PH_ACKHI: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_ACKSMP;
          end
          PH_ACKSMP: begin
            scl_reg_next   = 1'b0;
            nack_flag_next = held.sda_in;
            if (held.sda_in) begin
              phase_next = PH_SP1;
            end else begin
              bit_count_next = 4'd0;
              case (stage)
                SG_DEVW: begin
                  if (op_hold == OP_PROBE) begin
                    phase_next = PH_SP1;
                  end else if (short_hold) begin
                    shifter_next = reg_addr_hold[7:0];
                    stage_next   = SG_ADDRLO;
                    phase_next   = PH_TXLO;
                  end else begin
                    shifter_next = reg_addr_hold[15:8];
                    stage_next   = SG_ADDRHI;
                    phase_next   = PH_TXLO;
                  end
                end
                SG_ADDRHI: begin
                  shifter_next = reg_addr_hold[7:0];
                  stage_next   = SG_ADDRLO;
                  phase_next   = PH_TXLO;
                end
                SG_ADDRLO: begin
                  if (op_hold == OP_READ) begin
                    // repeated start, then device byte with the read flag
                    shifter_next = dev_hold | READ_FLAG;
                    stage_next   = SG_DEVR;
                    phase_next   = PH_ST1;
                  end else begin
                    stage_next = SG_DATA;
                    phase_next = (bytes_left == 16'd0) ? PH_SP1 : PH_WAIT;
                  end
                end
                SG_DATA: begin
                  bytes_left_next = bytes_dec;
                  phase_next      = (bytes_dec == 16'd0) ? PH_SP1 : PH_WAIT;
                end
                default: begin
                  phase_next = PH_RXREL;
                end
              endcase
            end
          end
          PH_RXREL: begin
            scl_reg_next   = 1'b0;
            sda_reg_next   = 1'b1;
            bit_count_next = 4'd0;
            shifter_next   = 8'd0;
            phase_next     = PH_RXLO;
          end
          PH_RXLO: begin
            // sample the bit clocked on the previous high phase
            if (bit_count != 4'd0) begin
              shifter_next = shift_in;
            end
            scl_reg_next = 1'b0;
            phase_next   = PH_RXHI;
          end
          PH_RXHI: begin
            scl_reg_next   = 1'b1;
            bit_count_next = bit_inc;
            phase_next     = (bit_inc >= 4'd8) ? PH_MALO : PH_RXLO;
          end
          PH_MALO: begin
            shifter_next       = shift_in;
            res_next.read_data  = shift_in;
            res_next.read_valid = 1'b1;
            res_next.read_last  = (bytes_left <= 16'd1);
            scl_reg_next       = 1'b0;
            sda_reg_next       = (bytes_left <= 16'd1);
            bit_count_next     = 4'd0;
            phase_next         = PH_MAHI;
          end
          PH_MAHI: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_MAREL;
          end
          PH_MAREL: begin
            scl_reg_next = 1'b0;
            sda_reg_next = 1'b1;
            if (bytes_left <= 16'd1) begin
              phase_next = PH_SP1;
            end else begin
              bytes_left_next = bytes_dec;
              phase_next      = PH_RXREL;
            end
          end
          PH_SP1: begin
            sda_reg_next = 1'b0;
            phase_next   = PH_SP2;
          end
          PH_SP2: begin
            scl_reg_next = 1'b1;
            phase_next   = PH_SP3;
          end
          PH_SP3: begin
            sda_reg_next      = 1'b1;
            res_next.done_res = 1'b1;
            phase_next        = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: ;
    endcase

    res_next.scl_level    = scl_reg_next;
    res_next.sda_level    = sda_reg_next;
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.status       = nack_flag_next;
    res_next.data_request = (phase_next == PH_WAIT) && !pending_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      stage         <= SG_DEVW;
      bit_count     <= 4'd0;
      shifter       <= 8'd0;
      bytes_left    <= 16'd0;
      reg_addr_hold <= 16'd0;
      dev_hold      <= 8'd0;
      op_hold       <= OP_PROBE;
      short_hold    <= 1'b0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      pending_byte  <= 8'd0;
      pending_valid <= 1'b0;
      nack_flag     <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      stage         <= stage_next;
      bit_count     <= bit_count_next;
      shifter       <= shifter_next;
      bytes_left    <= bytes_left_next;
      reg_addr_hold <= reg_addr_hold_next;
      dev_hold      <= dev_hold_next;
      op_hold       <= op_hold_next;
      short_hold    <= short_hold_next;
      scl_reg       <= scl_reg_next;
      sda_reg       <= sda_reg_next;
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
      nack_flag     <= nack_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign m_tdata = {1'b0, res.data_request, res.read_valid, res.read_data, res.status,
                    res.done_res, res.busy_res, res.sda_level, res.scl_level};
  assign m_tlast = res.read_last;

endmodule

// File: src/i2c_register_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_master_unit
// open-drain i2c master for probe, register write and register read
// transactions, stepped one pin change per tick request
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         start commands, write payload bytes, bus ticks
//  m_*       out        pin levels and status, one result per request
//
//  one request per cycle sustained while m_tready stays high; each request is
//  registered in the input register, then the sequencer updates its state and
//  the result register when the core takes it from the input register
//  rst clears the sequencer to idle with scl and sda released
//  a stalled m_tready holds the result; s_tready drops in the same cycle
//  once the input register is full too (at most two requests in flight)
// ----------------------------------------------------------------------------
module i2c_register_master_unit
  import i2crm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // operation, device_byte, register_address, short_address, transfer_length,
  // write_byte, sda_in, zero fill
  input  logic [InDataW-1:0]  s_tdata,
  // kind
  input  logic [InUserW-1:0]  s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // scl_level, sda_level, busy_res, done_res, status, read_data, read_valid,
  // data_request, zero fill
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tlast
);

  logic  take;
  logic  held_valid;
  item_t held;

  i2crm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  i2crm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held       (held),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// File: src/i2crm_checker.sv
// ----------------------------------------------------------------------------
// i2crm_checker
// port-level checks of the i2c register master result stream
// ----------------------------------------------------------------------------
module i2crm_checker
  import i2crm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tlast
);

  // stop completes with both lines released and the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2] && m_tdata[0] && m_tdata[1])
    else $error("done without idle released bus");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[13])
    else $error("read_last without read_valid");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14] |-> m_tdata[2] && !m_tdata[13])
    else $error("data_request while idle or reading");

  // a read byte completes with scl low
  a_read_scl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> !m_tdata[0] && m_tdata[2])
    else $error("read byte outside scl low phase");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind i2c_register_master_unit i2crm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: dv/i2c_register_master_unit_tb.sv
// ----------------------------------------------------------------------------
// i2c_register_master_unit_tb
// Drives probe, register write and register read transactions through the
// request stream. Ack levels and read data come from the sda_in field, and
// payload bytes arrive when the master asks for them. An in-bench model of
// the bus sequencer predicts every result, and each returned result is
// compared field by field. Sender gaps and receiver stalls vary by phase,
// and one long receiver hold-off fills the block until it stops taking
// requests.
// ----------------------------------------------------------------------------
module i2c_register_master_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2crm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 200;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  i2c_register_master_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the bus sequencer
  logic [4:0]  bus_phase;
  logic [2:0]  xfer_stage;
  logic [3:0]  bit_cnt;
  logic [7:0]  shift_reg;
  logic [15:0] bytes_remaining;
  logic [15:0] reg_addr;
  logic [7:0]  dev_addr;
  logic [1:0]  op_kind;
  logic        one_addr_byte;
  logic        scl_out;
  logic        sda_out;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic        nack_seen;

  result_t     pin_results[$];
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  function automatic result_t step_master(input item_t it);
    result_t r;
    r = '0;
    case (it.kind)
      KIND_START: begin
        if (bus_phase == PH_IDLE && it.operation != OP_INVALID) begin
          op_kind         = it.operation;
          dev_addr        = it.device_byte;
          reg_addr        = it.register_address;
          one_addr_byte   = it.short_address;
          bytes_remaining = it.transfer_length;
          if (it.operation == OP_READ && bytes_remaining == 16'd0) bytes_remaining = 16'd1;
          shift_reg  = it.device_byte;
          xfer_stage = SG_DEVW;
          bit_cnt    = 4'd0;
          nack_seen  = 1'b0;
          held_valid = 1'b0;
          bus_phase  = PH_ST1;
        end
      end
      KIND_BYTE: begin
        held_byte  = it.write_byte;
        held_valid = 1'b1;
      end
      KIND_TICK: begin
        case (bus_phase)
          PH_ST1: begin
            sda_out = 1'b1; bus_phase = PH_ST2;
          end
          PH_ST2: begin
            scl_out = 1'b1; bus_phase = PH_ST3;
          end
          PH_ST3: begin
            sda_out = 1'b0; bit_cnt = 4'd0; bus_phase = PH_TXLO;
          end
          PH_WAIT: begin
            // nothing moves until a payload byte is stored
            if (held_valid) begin
              shift_reg  = held_byte;
              held_valid = 1'b0;
              bit_cnt    = 4'd0;
              scl_out    = 1'b0;
              sda_out    = (shift_reg & MSB_MASK) != 8'd0;
              bus_phase  = PH_TXHI;
            end
          end
          PH_TXLO: begin
            scl_out   = 1'b0;
            sda_out   = (shift_reg & MSB_MASK) != 8'd0;
            bus_phase = PH_TXHI;
          end
          PH_TXHI: begin
            scl_out   = 1'b1;
            shift_reg = shift_reg << 1;
            bit_cnt   = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              bit_cnt   = 4'd0;
              bus_phase = PH_ACKLO;
            end else begin
              bus_phase = PH_TXLO;
            end
          end
          PH_ACKLO: begin
            scl_out = 1'b0; sda_out = 1'b1; bus_phase = PH_ACKHI;
          end
          PH_ACKHI: begin
            scl_out = 1'b1; bus_phase = PH_ACKSMP;
          end
          PH_ACKSMP: begin
            scl_out   = 1'b0;
            nack_seen = it.sda_in;
            if (nack_seen) begin
              bus_phase = PH_SP1;
            end else begin
              bit_cnt = 4'd0;
              case (xfer_stage)
                SG_DEVW: begin
                  if (op_kind == OP_PROBE) begin
                    bus_phase = PH_SP1;
                  end else begin
                    shift_reg  = one_addr_byte ? reg_addr[7:0] : reg_addr[15:8];
                    xfer_stage = one_addr_byte ? SG_ADDRLO : SG_ADDRHI;
                    bus_phase  = PH_TXLO;
                  end
                end
                SG_ADDRHI: begin
                  shift_reg  = reg_addr[7:0];
                  xfer_stage = SG_ADDRLO;
                  bus_phase  = PH_TXLO;
                end
                SG_ADDRLO: begin
                  if (op_kind == OP_READ) begin
                    // repeated start, then the device byte with the read flag
                    shift_reg  = dev_addr | READ_FLAG;
                    xfer_stage = SG_DEVR;
                    bus_phase  = PH_ST1;
                  end else begin
                    xfer_stage = SG_DATA;
                    bus_phase  = (bytes_remaining == 16'd0) ? PH_SP1 : PH_WAIT;
                  end
                end
                SG_DATA: begin
                  bytes_remaining = bytes_remaining - 16'd1;
                  bus_phase = (bytes_remaining == 16'd0) ? PH_SP1 : PH_WAIT;
                end
                default: bus_phase = PH_RXREL;
              endcase
            end
          end
          PH_RXREL: begin
            scl_out = 1'b0; sda_out = 1'b1; bit_cnt = 4'd0; shift_reg = 8'd0;
            bus_phase = PH_RXLO;
          end
          PH_RXLO: begin
            // the bit raised on the previous high phase is taken here
            if (bit_cnt != 4'd0) shift_reg = {shift_reg[6:0], it.sda_in};
            scl_out   = 1'b0;
            bus_phase = PH_RXHI;
          end
          PH_RXHI: begin
            scl_out   = 1'b1;
            bit_cnt   = bit_cnt + 4'd1;
            bus_phase = (bit_cnt >= 4'd8) ? PH_MALO : PH_RXLO;
          end
          PH_MALO: begin
            shift_reg    = {shift_reg[6:0], it.sda_in};
            r.read_data  = shift_reg;
            r.read_valid = 1'b1;
            r.read_last  = bytes_remaining <= 16'd1;
            scl_out      = 1'b0;
            sda_out      = r.read_last;
            bit_cnt      = 4'd0;
            bus_phase    = PH_MAHI;
          end
          PH_MAHI: begin
            scl_out = 1'b1; bus_phase = PH_MAREL;
          end
          PH_MAREL: begin
            scl_out = 1'b0;
            sda_out = 1'b1;
            if (bytes_remaining <= 16'd1) begin
              bus_phase = PH_SP1;
            end else begin
              bytes_remaining = bytes_remaining - 16'd1;
              bus_phase = PH_RXREL;
            end
          end
          PH_SP1: begin
            sda_out = 1'b0; bus_phase = PH_SP2;
          end
          PH_SP2: begin
            scl_out = 1'b1; bus_phase = PH_SP3;
          end
          PH_SP3: begin
            sda_out    = 1'b1;
            r.done_res = 1'b1;
            bus_phase  = PH_IDLE;
          end
          default: bus_phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    r.scl_level    = scl_out;
    r.sda_level    = sda_out;
    r.busy_res     = bus_phase != PH_IDLE;
    r.status       = nack_seen;
    r.data_request = bus_phase == PH_WAIT && !held_valid;
    return r;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it = '0;
    it.kind             = KIND_TICK;
    it.operation        = 2'($urandom_range(3));
    it.device_byte      = 8'($urandom_range(255));
    it.register_address = 16'($urandom_range(65535));
    it.short_address    = 1'($urandom_range(1));
    it.transfer_length  = 16'($urandom_range(65535));
    it.write_byte       = 8'($urandom_range(255));
    it.sda_in           = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it.sda_in, it.write_byte, it.transfer_length, it.short_address,
                 it.register_address, it.device_byte, it.operation};
    s_tuser  <= it.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    pin_results.push_back(step_master(it));
  endtask

  // one transaction: start request, then ticks until the stop completes;
  // payload bytes are offered when asked for, with a little noise mixed in
  task automatic run_transfer(input logic [1:0] op, input logic [7:0] dev,
                              input logic [15:0] addr, input logic one_byte,
                              input logic [15:0] len, input int unsigned nack_pct);
    item_t       it;
    int unsigned steps;
    int unsigned pick;
    int unsigned nack_now;
    it = random_item();
    it.kind             = KIND_START;
    it.operation        = op;
    it.device_byte      = dev;
    it.register_address = addr;
    it.short_address    = one_byte;
    it.transfer_length  = len;
    send_item(it);
    steps    = 0;
    nack_now = nack_pct;
    while (bus_phase != PH_IDLE) begin
      // long writes get cut short by a nack
      if (steps > 250) nack_now = 100;
      it   = random_item();
      pick = $urandom_range(99);
      if (bus_phase == PH_WAIT && !held_valid) begin
        if (pick < 85) it.kind = KIND_BYTE;
      end else if (pick < 4) begin
        it.kind = KIND_BYTE;
      end else if (pick < 7) begin
        it.kind = KIND_START;
      end else if (pick < 9) begin
        it.kind = KIND_NOOP;
      end
      if (bus_phase == PH_ACKSMP) it.sda_in = $urandom_range(99) < nack_now;
      send_item(it);
      steps++;
    end
  endtask

  task automatic test_idle_requests();
    item_t it;
    it = random_item();
    send_item(it);
    it.kind = KIND_NOOP;
    send_item(it);
    it.kind = KIND_BYTE;
    send_item(it);
    it.kind      = KIND_START;
    it.operation = OP_INVALID;
    send_item(it);
  endtask

  task automatic test_probe();
    run_transfer(OP_PROBE, 8'hFF, 16'h0000, 1'b0, 16'd0, 0);
    run_transfer(OP_PROBE, 8'h00, 16'hFFFF, 1'b1, 16'hFFFF, 100);
  endtask

  task automatic test_register_write();
    run_transfer(OP_WRITE, 8'hA0, 16'hFFFF, 1'b1, 16'd1, 0);
    run_transfer(OP_WRITE, 8'h5A, 16'h8001, 1'b0, 16'd0, 0);
    run_transfer(OP_WRITE, 8'h3C, 16'h00FF, 1'b0, 16'd2, 0);
  endtask

  task automatic test_register_read();
    run_transfer(OP_READ, 8'hA0, 16'h1234, 1'b1, 16'd0, 0);
    run_transfer(OP_READ, 8'hFE, 16'hFFFF, 1'b0, 16'd2, 0);
  endtask

  task automatic test_aborts();
    run_transfer(OP_WRITE, 8'h42, 16'hABCD, 1'b0, 16'hFFFF, 0);
    run_transfer(OP_READ, 8'hFF, 16'h0000, 1'b0, 16'hFFFF, 100);
    run_transfer(OP_WRITE, 8'h10, 16'h5555, 1'b1, 16'd3, 30);
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    run_transfer(OP_READ, 8'h90, 16'hC3A5, 1'b0, 16'd2, 0);
  endtask

  task automatic test_random();
    int unsigned target;
    int unsigned mode;
    logic [1:0]  op;
    logic [15:0] len;
    int unsigned nack_pct;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      target = requests_sent + RandomItems / 4;
      while (requests_sent < target) begin
        op       = 2'($urandom_range(3));
        len      = 16'($urandom_range(3));
        nack_pct = 5;
        if ($urandom_range(19) == 0) begin
          len      = 16'($urandom_range(65535));
          nack_pct = 100;
        end
        run_transfer(op, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                     1'($urandom_range(1)), len, nack_pct);
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // receiver side
  initial begin
    int unsigned n;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch %s: got %0h expected %0h (cycle %0d)", field, got, want,
               cycle_count);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pin_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_tdata), 0);
      end else begin
        want = pin_results.pop_front();
        if (m_tdata[0] !== want.scl_level)
          report_mismatch("scl_level", 32'(m_tdata[0]), 32'(want.scl_level));
        if (m_tdata[1] !== want.sda_level)
          report_mismatch("sda_level", 32'(m_tdata[1]), 32'(want.sda_level));
        if (m_tdata[2] !== want.busy_res)
          report_mismatch("busy_res", 32'(m_tdata[2]), 32'(want.busy_res));
        if (m_tdata[3] !== want.done_res)
          report_mismatch("done_res", 32'(m_tdata[3]), 32'(want.done_res));
        if (m_tdata[4] !== want.status)
          report_mismatch("status", 32'(m_tdata[4]), 32'(want.status));
        if (m_tdata[12:5] !== want.read_data)
          report_mismatch("read_data", 32'(m_tdata[12:5]), 32'(want.read_data));
        if (m_tdata[13] !== want.read_valid)
          report_mismatch("read_valid", 32'(m_tdata[13]), 32'(want.read_valid));
        if (m_tlast !== want.read_last)
          report_mismatch("read_last", 32'(m_tlast), 32'(want.read_last));
        if (m_tdata[14] !== want.data_request)
          report_mismatch("data_request", 32'(m_tdata[14]), 32'(want.data_request));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    bus_phase       = PH_IDLE;
    xfer_stage      = SG_DEVW;
    bit_cnt         = 4'd0;
    shift_reg       = 8'd0;
    bytes_remaining = 16'd0;
    reg_addr        = 16'd0;
    dev_addr        = 8'd0;
    op_kind         = OP_PROBE;
    one_addr_byte   = 1'b0;
    scl_out         = 1'b1;
    sda_out         = 1'b1;
    held_byte       = 8'd0;
    held_valid      = 1'b0;
    nack_seen       = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_requests();
    test_probe();
    test_register_write();
    test_register_read();
    test_aborts();
    test_backpressure();
    test_random();

    s_tvalid <= 1'b0;
    while (pin_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: i2c_register_master_unit.f
src/i2crm_pkg.sv
src/i2crm_in_stage.sv
src/i2crm_core.sv
src/i2c_register_master_unit.sv
src/i2crm_checker.sv
dv/i2c_register_master_unit_tb.sv
